@@ rtl/key_transition_tracker_top_macros.svh @@
// ----------------------------------------------------------------------------
// Key transition tracker assertion macros
// Shared concurrent assertion forms, clocked on clock and gated by reset.
// ----------------------------------------------------------------------------
`ifndef KEY_TRANSITION_TRACKER_TOP_MACROS_SVH
`define KEY_TRANSITION_TRACKER_TOP_MACROS_SVH

// cond holds -> conseq holds in the same cycle
`define KTT_ASSERT_SAME(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond) |-> (conseq)) else $error(msg);

// cond holds -> conseq sequence starts in the next cycle
`define KTT_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond) |=> conseq) else $error(msg);

`endif

@@ rtl/ktt_pkg.sv @@
// ----------------------------------------------------------------------------
// ktt_pkg
// Types and fixed codes for the key transition tracker.
// ----------------------------------------------------------------------------
package ktt_pkg;

   // request modes
   localparam logic [1:0] MODE_EVENT  = 2'd0;
   localparam logic [1:0] MODE_POP    = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [15:0] EVENT_KEY    = 16'h0001;
   localparam logic [31:0] VALUE_REPEAT = 32'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] event_type;
      logic [15:0] key_code;
      logic [31:0] key_value;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [6:0] out_code;
      logic       out_down;
   } rsp_type;

   // one stored transition
   typedef struct packed {
      logic [6:0] code;
      logic       down;
   } ring_entry_type;

   // decoded operation for the current item
   typedef struct packed {
      logic key_event;   // key event with in-range code: update held map
      logic push;        // record a transition
      logic pop;         // take the oldest transition (ring not empty)
      logic down;        // new key state
   } op_type;

endpackage

@@ rtl/key_transition_tracker_top.sv @@
// ----------------------------------------------------------------------------
// key_transition_tracker_top
// Held-key bitmap plus an overwrite-oldest ring of key transitions.
// ----------------------------------------------------------------------------
// Takes one request per cycle (busy is never raised) and answers pops and
// queries after the start transfer as follows: the request is captured in an
// input register, decoded and applied to the held map and ring in the next
// cycle, and the answer is loaded into the result register, so rsp_strobe
// rises the cycle after that. Throughput is one item per clock; the single
// write and single registered read port of the ring memory and one bitmap
// bit per item set that figure. Events never produce a result transfer.
// The receiver cannot stall: a result is on rsp_data for one cycle only.
// ----------------------------------------------------------------------------
`include "key_transition_tracker_top_macros.svh"

module key_transition_tracker_top #(
   parameter int RING_DEPTH = 64,
   parameter int KEY_CODES  = 128
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             start,
   output logic             busy,
   input  ktt_pkg::req_type req_data,
   // result channel
   output logic             rsp_strobe,
   output ktt_pkg::rsp_type rsp_data
);
   import ktt_pkg::*;

   localparam int CW = $clog2(KEY_CODES);

   // input register
   logic    req_valid_ff;
   req_type req_ff;

   // decode
   op_type         op;
   ring_entry_type wr_entry;
   ring_entry_type rd_entry;
   logic           in_range;
   logic           key_down;
   logic           held;
   logic           avail;
   logic           is_pop, is_query;

   // result register
   logic rsp_strobe_ff, rsp_strobe_in;
   logic found_ff, found_in;
   logic use_ring_ff, use_ring_in;

   // accepted requests that owe an answer, or must stay silent
   logic answer_req;
   logic silent_req;

   // never stalls: one transfer per cycle
   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start & ~busy) begin
         req_ff <= req_data;
      end
   end

   assign in_range = (req_ff.key_code < 16'(KEY_CODES));
   assign key_down = (req_ff.key_value != '0);

   always_comb begin
      is_pop   = 1'b0;
      is_query = 1'b0;
      op       = '0;
      case (req_ff.mode)
         MODE_EVENT: begin
            op.key_event = req_valid_ff && (req_ff.event_type == EVENT_KEY) && in_range;
            // auto-repeat refreshes the map but is not a transition
            op.push      = op.key_event && (req_ff.key_value != VALUE_REPEAT);
         end
         MODE_POP: begin
            is_pop = req_valid_ff;
            op.pop = req_valid_ff && avail;
         end
         MODE_QUERY: begin
            is_query = req_valid_ff;
         end
         default: begin
            // unused mode: dropped
         end
      endcase
      op.down = key_down;
   end

   assign wr_entry.code = req_ff.key_code[6:0];
   assign wr_entry.down = key_down;

   ktt_held_map #(
      .KEY_CODES (KEY_CODES)
   ) u_held_map (
      .clock (clock),
      .reset (reset),
      .op    (op),
      .code  (req_ff.key_code[CW-1:0]),
      .held  (held)
   );

   ktt_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock    (clock),
      .reset    (reset),
      .op       (op),
      .wr_entry (wr_entry),
      .avail    (avail),
      .rd_entry (rd_entry)
   );

   // result: pops and queries answer, events stay silent
   always_comb begin
      rsp_strobe_in = is_pop | is_query;
      use_ring_in   = op.pop;
      found_in      = op.pop | (is_query & in_range & held);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
         use_ring_ff   <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
         use_ring_ff   <= use_ring_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
   end

   // ring read data lands with the result register; zero it unless popped
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_data.found    = found_ff & rsp_strobe_ff;
   assign rsp_data.out_code = use_ring_ff ? rd_entry.code : 7'd0;
   assign rsp_data.out_down = use_ring_ff & rd_entry.down;

   assign answer_req = start && !busy &&
                       (req_data.mode == MODE_POP || req_data.mode == MODE_QUERY);
   assign silent_req = start && !busy &&
                       (req_data.mode == MODE_EVENT || req_data.mode == MODE_UNUSED);

   // pop and query transfers answer through the input and result registers
   `KTT_ASSERT_NEXT(a_answer, answer_req, ##1 rsp_strobe, "pop or query got no result transfer")

   // events and unused modes never answer
   `KTT_ASSERT_NEXT(a_silent, silent_req, ##1 !rsp_strobe, "event produced a result transfer")

   // ring data only ever goes out with a found pop
   `KTT_ASSERT_SAME(a_ring_found, use_ring_ff, rsp_data.found, "ring read without a found pop")

endmodule

@@ rtl/ktt_held_map.sv @@
// ----------------------------------------------------------------------------
// ktt_held_map
// One flop per key code holding its pressed state; single-bit lookup.
// ----------------------------------------------------------------------------
module ktt_held_map #(
   parameter int KEY_CODES = 128
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ktt_pkg::op_type              op,
   input  logic [$clog2(KEY_CODES)-1:0] code,
   output logic                         held
);
   import ktt_pkg::*;

   logic [KEY_CODES-1:0] held_ff;
   logic [KEY_CODES-1:0] held_in;

   always_comb begin
      held_in = held_ff;
      if (op.key_event) begin
         held_in[code] = op.down;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   assign held = held_ff[code];

endmodule

@@ rtl/ktt_ring.sv @@
// ----------------------------------------------------------------------------
// ktt_ring
// Transition ring that drops its oldest entry when full; registered read.
// ----------------------------------------------------------------------------
module ktt_ring #(
   parameter int RING_DEPTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ktt_pkg::op_type         op,
   input  ktt_pkg::ring_entry_type wr_entry,
   output logic                    avail,
   output ktt_pkg::ring_entry_type rd_entry
);
   import ktt_pkg::*;

   localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam logic [PW-1:0] LAST = PW'(RING_DEPTH - 1);

   ring_entry_type mem [RING_DEPTH];
   ring_entry_type rd_ff;

   logic [PW-1:0] wp_ff, wp_in;
   logic [PW-1:0] rp_ff, rp_in;
   logic [PW-1:0] wp_next, rp_next;

   assign wp_next = (wp_ff == LAST) ? '0 : wp_ff + PW'(1);
   assign rp_next = (rp_ff == LAST) ? '0 : rp_ff + PW'(1);
   assign avail   = (wp_ff != rp_ff);

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      if (op.push) begin
         wp_in = wp_next;
         // writing into the slot just behind the reader: drop the oldest
         if (wp_next == rp_ff) begin
            rp_in = rp_next;
         end
      end else if (op.pop) begin
         rp_in = rp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op.push) begin
         mem[wp_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (op.pop) begin
         rd_ff <= mem[rp_ff];
      end
   end

   assign rd_entry = rd_ff;

endmodule
